// ===== rtl/sqs_pkg.sv =====
// ----------------------------------------------------------------------------
// sqs_pkg
// Shared types, constants and arithmetic helpers of the sprite quad setup.
// ----------------------------------------------------------------------------
`default_nettype none

package sqs_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int ANGLE_BITS   = 16;
    localparam int NUM_VERTS    = 6;
    localparam int DIV_STEPS    = 37;
    localparam int PW           = 60;

    localparam logic [2:0] LAST_VTX = 3'(NUM_VERTS - 1);

    localparam logic [1:0] CFG_NDC_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_VIEW_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_VIEW_HEIGHT = 2'd2;

    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic               kind;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic [22:0]        w;
        logic [22:0]        h;
        logic [31:0]        color;
        logic [16:0]        u0;
        logic [16:0]        v0;
        logic [16:0]        u1;
        logic [16:0]        v1;
        logic               swap;
    } sprite_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
        logic [1:0]         quad;
    } cordic_t;

    typedef struct packed {
        logic signed [57:0] wc;
        logic signed [57:0] ws;
        logic signed [57:0] hc;
        logic signed [57:0] hs;
    } prod_t;

    typedef struct packed {
        logic [36:0] a;
        logic [15:0] rem;
        logic        neg;
        logic [31:0] pix;
    } axis_t;

    typedef struct packed {
        axis_t       x;
        axis_t       y;
        logic        ndc;
        logic [31:0] color;
        logic [16:0] u;
        logic [16:0] v;
        logic        last;
    } vtx_t;

    // one rotation-mode micro-rotation, shifts floor toward minus infinity
    function automatic cordic_t cordic_step(cordic_t c, logic [4:0] idx);
        cordic_t            r;
        logic signed [33:0] xs;
        logic signed [33:0] ys;
        logic signed [32:0] at;
        xs = c.x >>> idx;
        ys = c.y >>> idx;
        at = $signed({1'b0, ATAN_TAB[idx]});
        r  = c;
        if (!c.z[32])
        begin
            r.x = c.x - ys;
            r.y = c.y + xs;
            r.z = c.z - at;
        end
        else
        begin
            r.x = c.x + ys;
            r.y = c.y - xs;
            r.z = c.z + at;
        end
        return r;
    endfunction

    // one restoring division step, quotient bit shifts into the dividend
    function automatic axis_t div_step(axis_t s, logic [15:0] dvsr);
        axis_t       r;
        logic [16:0] trial;
        logic        ge;
        trial = {s.rem, s.a[36]};
        ge    = trial >= {1'b0, dvsr};
        r     = s;
        r.rem = ge ? 16'(trial - {1'b0, dvsr}) : trial[15:0];
        r.a   = {s.a[35:0], ge};
        return r;
    endfunction

    function automatic logic [31:0] sat32(logic signed [38:0] v);
        logic [31:0] r;
        if (v > $signed(39'h0_7FFF_FFFF))
            r = 32'h7FFF_FFFF;
        else if (v < $signed(39'h7F_8000_0000))
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // corner index of each emitted vertex: TL TR BL / TR BR BL
    function automatic logic [1:0] vert_corner(logic [2:0] n);
        logic [1:0] r;
        unique case (n)
            3'd0:    r = 2'd0;
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd1;
            3'd4:    r = 2'd3;
            default: r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sqs_sprite_if.sv =====
// ----------------------------------------------------------------------------
// sqs_sprite_if
// Sprite rectangle channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface sqs_sprite_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [22:0]        rect_width;
    logic [22:0]        rect_height;
    logic [15:0]        angle;
    logic [31:0]        color_word;
    logic [16:0]        tex_u0;
    logic [16:0]        tex_v0;
    logic [16:0]        tex_u1;
    logic [16:0]        tex_v1;
    logic               swap_uv;

    modport source (output valid, kind, pos_x, pos_y, rect_width, rect_height, angle,
                    color_word, tex_u0, tex_v0, tex_u1, tex_v1, swap_uv, input ready);
    modport sink   (input valid, kind, pos_x, pos_y, rect_width, rect_height, angle,
                    color_word, tex_u0, tex_v0, tex_u1, tex_v1, swap_uv, output ready);
endinterface

`default_nettype wire

// ===== rtl/sqs_vertex_if.sv =====
// ----------------------------------------------------------------------------
// sqs_vertex_if
// Vertex channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface sqs_vertex_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic [31:0]        vert_color;
    logic [16:0]        vert_u;
    logic [16:0]        vert_v;
    logic               last_vertex;

    modport source (output valid, vert_x, vert_y, vert_color, vert_u, vert_v, last_vertex,
                    input ready);
    modport sink   (input valid, vert_x, vert_y, vert_color, vert_u, vert_v, last_vertex,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/sqs_cfg_if.sv =====
// ----------------------------------------------------------------------------
// sqs_cfg_if
// Register write channel, valid/ready with index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface sqs_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sprite_quad_setup_top.sv =====
// ----------------------------------------------------------------------------
// sprite_quad_setup_top
// Turns each sprite rectangle into six vertices (TL TR BL / TR BR BL), with
// optional rotation about the centre, UV swizzle and NDC mapping.
// A sprite is taken in one transfer and leaves as six vertex transfers, one
// per cycle while the vertex sink is ready; the vertex sequencer sets that
// rate. Sprites may be taken back to back while earlier ones are still in
// flight. From sprite transfer to the first vertex the path runs through an
// input register, 24 CORDIC stages, a multiply stage, the vertex sequencer,
// a prepare stage, 37 pipelined divide steps for the NDC scaling and the
// output register. Register writes are taken every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_quad_setup_top (
    input  wire               clk,
    input  wire               rst_n,
    sqs_sprite_if.sink        sprite,
    sqs_vertex_if.source      vertex,
    sqs_cfg_if.sink           cfg
);

    // configuration registers
    logic        ndc_enable_reg;
    logic [15:0] view_width_reg;
    logic [15:0] view_height_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ndc_enable_reg  <= 1'b0;
            view_width_reg  <= 16'd1280;
            view_height_reg <= 16'd720;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == sqs_pkg::CFG_NDC_ENABLE)
                ndc_enable_reg <= cfg.data[0];
            if (cfg.index == sqs_pkg::CFG_VIEW_WIDTH)
                view_width_reg <= cfg.data;
            if (cfg.index == sqs_pkg::CFG_VIEW_HEIGHT)
                view_height_reg <= cfg.data;
        end
    end

    // flow control
    logic out_valid_reg;
    logic back_en;
    logic front_en;
    logic seq_free;
    logic seq_load;
    logic seq_valid_reg;
    logic [2:0] seq_cnt_reg;
    logic mul_valid_reg;

    assign back_en  = !out_valid_reg || vertex.ready;
    assign seq_free = !seq_valid_reg || (back_en && seq_cnt_reg == sqs_pkg::LAST_VTX);
    assign seq_load = mul_valid_reg && seq_free;
    assign front_en = !mul_valid_reg || seq_free;
    assign sprite.ready = front_en;

    // input register
    logic             f0_valid_reg;
    sqs_pkg::sprite_t f0_reg;
    sqs_pkg::sprite_t f0_next;

    always_comb
    begin
        f0_next.kind  = sprite.kind;
        f0_next.px    = sprite.pos_x;
        f0_next.py    = sprite.pos_y;
        f0_next.w     = sprite.rect_width;
        f0_next.h     = sprite.rect_height;
        f0_next.color = sprite.color_word;
        f0_next.u0    = sprite.tex_u0;
        f0_next.v0    = sprite.tex_v0;
        f0_next.u1    = sprite.tex_u1;
        f0_next.v1    = sprite.tex_v1;
        f0_next.swap  = sprite.swap_uv;
    end

    logic [15:0] f0_angle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f0_valid_reg <= 1'b0;
        else if (front_en)
            f0_valid_reg <= sprite.valid;
    end

    always_ff @(posedge clk)
    begin
        if (front_en)
        begin
            f0_reg       <= f0_next;
            f0_angle_reg <= sprite.angle;
        end
    end

    // quadrant reduction of the binary angle
    logic [31:0]      phase;
    logic [31:0]      phase_rnd;
    sqs_pkg::cordic_t cd_init;

    always_comb
    begin
        phase         = {f0_angle_reg, 16'd0};
        phase_rnd     = phase + 32'h2000_0000;
        cd_init.quad  = phase_rnd[31:30];
        cd_init.x     = sqs_pkg::CORDIC_START;
        cd_init.y     = '0;
        cd_init.z     = $signed({phase[31], 32'(phase - {phase_rnd[31:30], 30'd0})});
        // residual is below an eighth of a turn, sign lives in bit 31
        cd_init.z[32] = cd_init.z[31];
    end

    // CORDIC pipeline, one micro-rotation per stage
    logic             cd_valid_reg [sqs_pkg::CORDIC_STEPS];
    sqs_pkg::cordic_t cd_reg       [sqs_pkg::CORDIC_STEPS];
    sqs_pkg::sprite_t cp_reg       [sqs_pkg::CORDIC_STEPS];

    for (genvar i = 0; i < sqs_pkg::CORDIC_STEPS; i++)
    begin : g_cordic
        sqs_pkg::cordic_t cd_next;
        logic             v_in;
        sqs_pkg::sprite_t p_in;

        if (i == 0)
        begin : g_first
            assign cd_next = sqs_pkg::cordic_step(cd_init, 5'(i));
            assign v_in    = f0_valid_reg;
            assign p_in    = f0_reg;
        end
        else
        begin : g_rest
            assign cd_next = sqs_pkg::cordic_step(cd_reg[i-1], 5'(i));
            assign v_in    = cd_valid_reg[i-1];
            assign p_in    = cp_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cd_valid_reg[i] <= 1'b0;
            else if (front_en)
                cd_valid_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (front_en)
            begin
                cd_reg[i] <= cd_next;
                cp_reg[i] <= p_in;
            end
        end
    end

    // quadrant fix-up and the four products
    sqs_pkg::cordic_t   cd_last;
    logic signed [33:0] cos_v;
    logic signed [33:0] sin_v;
    logic signed [23:0] w_s;
    logic signed [23:0] h_s;
    sqs_pkg::prod_t     prod_next;
    sqs_pkg::prod_t     prod_reg;
    sqs_pkg::sprite_t   mp_reg;

    assign cd_last = cd_reg[sqs_pkg::CORDIC_STEPS-1];

    always_comb
    begin
        unique case (cd_last.quad)
            2'd0:
            begin
                cos_v = cd_last.x;
                sin_v = cd_last.y;
            end
            2'd1:
            begin
                cos_v = -cd_last.y;
                sin_v = cd_last.x;
            end
            2'd2:
            begin
                cos_v = -cd_last.x;
                sin_v = -cd_last.y;
            end
            default:
            begin
                cos_v = cd_last.y;
                sin_v = -cd_last.x;
            end
        endcase
        w_s = $signed({1'b0, cp_reg[sqs_pkg::CORDIC_STEPS-1].w});
        h_s = $signed({1'b0, cp_reg[sqs_pkg::CORDIC_STEPS-1].h});
        prod_next.wc = w_s * cos_v;
        prod_next.ws = w_s * sin_v;
        prod_next.hc = h_s * cos_v;
        prod_next.hs = h_s * sin_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_valid_reg <= 1'b0;
        else if (front_en)
            mul_valid_reg <= cd_valid_reg[sqs_pkg::CORDIC_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (front_en)
        begin
            prod_reg <= prod_next;
            mp_reg   <= cp_reg[sqs_pkg::CORDIC_STEPS-1];
        end
    end

    // corner positions, raw * 2^31
    logic signed [sqs_pkg::PW-1:0] cx_next [4];
    logic signed [sqs_pkg::PW-1:0] cy_next [4];
    logic [16:0]                   cu_next [4];
    logic [16:0]                   cv_next [4];

    always_comb
    begin
        logic signed [sqs_pkg::PW-1:0] pxe;
        logic signed [sqs_pkg::PW-1:0] pye;
        logic signed [sqs_pkg::PW-1:0] wc;
        logic signed [sqs_pkg::PW-1:0] ws;
        logic signed [sqs_pkg::PW-1:0] hc;
        logic signed [sqs_pkg::PW-1:0] hs;
        logic signed [24:0]            ax;
        logic signed [24:0]            ay;
        pxe = sqs_pkg::PW'(mp_reg.px) <<< 31;
        pye = sqs_pkg::PW'(mp_reg.py) <<< 31;
        wc  = sqs_pkg::PW'(prod_reg.wc);
        ws  = sqs_pkg::PW'(prod_reg.ws);
        hc  = sqs_pkg::PW'(prod_reg.hc);
        hs  = sqs_pkg::PW'(prod_reg.hs);
        for (int k = 0; k < 4; k++)
        begin
            ax = 25'(mp_reg.px) + ((k % 2 == 1) ? $signed({2'b0, mp_reg.w}) : 25'sd0);
            ay = 25'(mp_reg.py) + ((k / 2 == 1) ? $signed({2'b0, mp_reg.h}) : 25'sd0);
            if (mp_reg.kind)
            begin
                cx_next[k] = pxe + ((k % 2 == 1) ? wc : -wc) - ((k / 2 == 1) ? hs : -hs);
                cy_next[k] = pye + ((k % 2 == 1) ? ws : -ws) + ((k / 2 == 1) ? hc : -hc);
            end
            else
            begin
                cx_next[k] = sqs_pkg::PW'(ax) <<< 31;
                cy_next[k] = sqs_pkg::PW'(ay) <<< 31;
            end
        end
        // atlas swizzle
        if (mp_reg.swap)
        begin
            cu_next = '{mp_reg.u0, mp_reg.u0, mp_reg.u1, mp_reg.u1};
            cv_next = '{mp_reg.v1, mp_reg.v0, mp_reg.v1, mp_reg.v0};
        end
        else
        begin
            cu_next = '{mp_reg.u0, mp_reg.u1, mp_reg.u0, mp_reg.u1};
            cv_next = '{mp_reg.v0, mp_reg.v0, mp_reg.v1, mp_reg.v1};
        end
    end

    // vertex sequencer
    logic signed [sqs_pkg::PW-1:0] sx_reg [4];
    logic signed [sqs_pkg::PW-1:0] sy_reg [4];
    logic [16:0]                   su_reg [4];
    logic [16:0]                   sv_reg [4];
    logic [31:0]                   scol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_valid_reg <= 1'b0;
            seq_cnt_reg   <= '0;
        end
        else if (seq_load)
        begin
            seq_valid_reg <= 1'b1;
            seq_cnt_reg   <= '0;
        end
        else if (back_en && seq_valid_reg)
        begin
            if (seq_cnt_reg == sqs_pkg::LAST_VTX)
                seq_valid_reg <= 1'b0;
            else
                seq_cnt_reg <= seq_cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_load)
        begin
            sx_reg   <= cx_next;
            sy_reg   <= cy_next;
            su_reg   <= cu_next;
            sv_reg   <= cv_next;
            scol_reg <= mp_reg.color;
        end
    end

    // prepare: rounding offsets and sign folding for the floor division
    logic        ndc_on;
    logic [1:0]  corner;
    sqs_pkg::vtx_t prep_next;

    assign ndc_on = ndc_enable_reg && view_width_reg != 16'd0 && view_height_reg != 16'd0;
    assign corner = sqs_pkg::vert_corner(seq_cnt_reg);

    function automatic sqs_pkg::axis_t prep_axis(logic signed [sqs_pkg::PW-1:0] p,
                                                 logic [15:0] view);
        sqs_pkg::axis_t                r;
        logic signed [sqs_pkg::PW-1:0] n;
        logic signed [sqs_pkg::PW-1:0] t;
        logic signed [36:0]            pv;
        n     = p + $signed({23'd0, view, 21'd0});
        t     = p + $signed(sqs_pkg::PW'(1) <<< 22);
        pv    = t[sqs_pkg::PW-1:23];
        r.neg = n[sqs_pkg::PW-1];
        // floor of a negative quotient is the complement of the quotient of the complement
        r.a   = r.neg ? ~n[58:22] : n[58:22];
        r.rem = '0;
        r.pix = sqs_pkg::sat32(39'(pv));
        return r;
    endfunction

    always_comb
    begin
        prep_next.x     = prep_axis(sx_reg[corner], view_width_reg);
        prep_next.y     = prep_axis(sy_reg[corner], view_height_reg);
        prep_next.ndc   = ndc_on;
        prep_next.color = scol_reg;
        prep_next.u     = su_reg[corner];
        prep_next.v     = sv_reg[corner];
        prep_next.last  = seq_cnt_reg == sqs_pkg::LAST_VTX;
    end

    // divide pipeline, stage 0 holds the prepared vertex
    logic          dv_valid_reg [sqs_pkg::DIV_STEPS+1];
    sqs_pkg::vtx_t dv_reg       [sqs_pkg::DIV_STEPS+1];

    for (genvar j = 0; j <= sqs_pkg::DIV_STEPS; j++)
    begin : g_div
        sqs_pkg::vtx_t dv_next;
        logic          v_in;

        if (j == 0)
        begin : g_first
            assign dv_next = prep_next;
            assign v_in    = seq_valid_reg;
        end
        else
        begin : g_rest
            always_comb
            begin
                dv_next   = dv_reg[j-1];
                dv_next.x = sqs_pkg::div_step(dv_reg[j-1].x, view_width_reg);
                dv_next.y = sqs_pkg::div_step(dv_reg[j-1].y, view_height_reg);
            end
            assign v_in = dv_valid_reg[j-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[j] <= 1'b0;
            else if (back_en)
                dv_valid_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (back_en)
                dv_reg[j] <= dv_next;
        end
    end

    // final offset, saturation and output register
    sqs_pkg::vtx_t dv_last;
    logic [31:0]   ox_next;
    logic [31:0]   oy_next;
    logic [31:0]   ox_reg;
    logic [31:0]   oy_reg;
    logic [31:0]   ocol_reg;
    logic [16:0]   ou_reg;
    logic [16:0]   ov_reg;
    logic          olast_reg;

    assign dv_last = dv_reg[sqs_pkg::DIV_STEPS];

    function automatic logic [31:0] ndc_out(sqs_pkg::axis_t s);
        logic signed [37:0] q;
        logic signed [38:0] r;
        q = s.neg ? ~$signed({1'b0, s.a}) : $signed({1'b0, s.a});
        r = 39'(q) - 39'sd65536;
        return sqs_pkg::sat32(r);
    endfunction

    assign ox_next = dv_last.ndc ? ndc_out(dv_last.x) : dv_last.x.pix;
    assign oy_next = dv_last.ndc ? ndc_out(dv_last.y) : dv_last.y.pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (back_en)
            out_valid_reg <= dv_valid_reg[sqs_pkg::DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            ox_reg    <= ox_next;
            oy_reg    <= oy_next;
            ocol_reg  <= dv_last.color;
            ou_reg    <= dv_last.u;
            ov_reg    <= dv_last.v;
            olast_reg <= dv_last.last;
        end
    end

    assign vertex.valid       = out_valid_reg;
    assign vertex.vert_x      = $signed(ox_reg);
    assign vertex.vert_y      = $signed(oy_reg);
    assign vertex.vert_color  = ocol_reg;
    assign vertex.vert_u      = ou_reg;
    assign vertex.vert_v      = ov_reg;
    assign vertex.last_vertex = olast_reg;

    // checks
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        seq_valid_reg |-> seq_cnt_reg <= sqs_pkg::LAST_VTX)
        else $error("vertex counter out of range");

    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (back_en && seq_valid_reg && seq_cnt_reg == sqs_pkg::LAST_VTX)
        |=> (dv_valid_reg[0] && dv_reg[0].last))
        else $error("sixth vertex not marked last");

    a_mul_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_valid_reg && !front_en) |=> mul_valid_reg)
        else $error("stalled sprite dropped before sequencing");

    a_seq_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !seq_valid_reg |-> front_en)
        else $error("front pipeline stalled with idle sequencer");

endmodule

`default_nettype wire
